[hw/rtl/rfr_pkg.sv]
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared types and constants of the Raft follower message handler.
// ----------------------------------------------------------------------------
package rfr_pkg;

	// Log table geometry
	localparam int LOG_DEPTH = 1024;
	localparam int LOG_AW    = $clog2(LOG_DEPTH);

	// Field widths
	localparam int OP_W   = 2;
	localparam int TERM_W = 32;
	localparam int PEER_W = 4;
	localparam int IDX_W  = 11;
	localparam int NEXT_W = 12;

	// Message codes
	localparam logic [OP_W-1:0] OP_VOTE   = 2'd0;
	localparam logic [OP_W-1:0] OP_HEADER = 2'd1;
	localparam logic [OP_W-1:0] OP_ENTRY  = 2'd2;

	// Reply codes
	localparam logic KIND_VOTE   = 1'b0;
	localparam logic KIND_APPEND = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [TERM_W-1:0] msg_term;
		logic [PEER_W-1:0] peer_id;
		logic [IDX_W-1:0]  index_arg;
		logic [TERM_W-1:0] term_arg;
		logic [IDX_W-1:0]  leader_commit;
		logic [IDX_W-1:0]  entry_count;
		logic [TERM_W-1:0] entry_term;
	} req_t;

	typedef struct packed {
		logic              reply_kind;
		logic [TERM_W-1:0] reply_term;
		logic              ok;
		logic [IDX_W-1:0]  conflict_index;
		logic [TERM_W-1:0] conflict_term;
		logic [IDX_W-1:0]  commit_now;
		logic [PEER_W-1:0] leader_now;
		logic              log_full;
	} rsp_t;

	// Term table read and write request
	typedef struct packed {
		logic              rd_en;
		logic [LOG_AW-1:0] rd_addr;
		logic              wr_en;
		logic [LOG_AW-1:0] wr_addr;
		logic [TERM_W-1:0] wr_data;
	} mem_req_t;

endpackage

[hw/rtl/rfr_ifs.sv]
// ----------------------------------------------------------------------------
// rfr_req_if / rfr_rsp_if
// Valid/ready channels carrying message words and reply words.
// ----------------------------------------------------------------------------
interface rfr_req_if import rfr_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rfr_rsp_if import rfr_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/rfr_term_mem.sv]
// ----------------------------------------------------------------------------
// rfr_term_mem
// Log entry term table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rfr_term_mem import rfr_pkg::*; (
	input  logic              clk,
	input  mem_req_t          req,
	output logic [TERM_W-1:0] rd_data
);

	logic [TERM_W-1:0] mem [LOG_DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Read and hold until the next read
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

[hw/rtl/raft_follower_rpc_handler_unit.sv]
// ----------------------------------------------------------------------------
// raft_follower_rpc_handler_unit
// Follower side of Raft: vote requests, append headers and append entries.
// ----------------------------------------------------------------------------
// A taken word is held in item_s1 with its registered term table read; its reply
// word is registered in rsp_q when the decision fires. No new message word is
// taken until then: each word is read in ST_IDLE and decided in ST_EXEC.
// A stalled reply holds the decision cycle until the reply register frees up.
// Reset clears all control state; the term table is not cleared, and its read
// data is only ever used below the log length, which covers written entries.
module raft_follower_rpc_handler_unit import rfr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	rfr_req_if.sink    req,
	rfr_rsp_if.source  rsp
);

	typedef enum logic {ST_IDLE, ST_EXEC} state_t;

	state_t            state_q;
	req_t              item_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [TERM_W-1:0] cur_term_q;
	logic              voted_valid_q;
	logic [PEER_W-1:0] voted_for_q;
	logic [PEER_W-1:0] leader_q;
	logic [IDX_W-1:0]  log_len_q;
	logic [IDX_W-1:0]  commit_q;
	logic [IDX_W-1:0]  pending_q;
	logic [NEXT_W-1:0] next_idx_q;
	logic [IDX_W-1:0]  hdr_commit_q;
	logic              skip_q;
	logic              ovf_q;

	logic [TERM_W-1:0] term_d;
	logic              voted_valid_d;
	logic [PEER_W-1:0] voted_for_d;
	logic [PEER_W-1:0] leader_d;
	logic [IDX_W-1:0]  log_len_d;
	logic [IDX_W-1:0]  commit_d;
	logic [IDX_W-1:0]  pending_d;
	logic [NEXT_W-1:0] next_idx_d;
	logic [IDX_W-1:0]  hdr_commit_d;
	logic              skip_d;
	logic              ovf_d;

	logic              accept;
	logic              fire;
	logic              has_res;
	rsp_t              res;
	mem_req_t          mem_req;
	logic [TERM_W-1:0] rd_data;
	logic [NEXT_W-1:0] rd_idx;
	logic [NEXT_W-1:0] rd_idx_m1;
	logic              wr_en;
	logic [LOG_AW-1:0] wr_addr;

	// Commit advance at the end of an append
	function automatic logic [IDX_W-1:0] commit_calc(
		input logic [IDX_W-1:0]  hdr,
		input logic [IDX_W-1:0]  cur,
		input logic [IDX_W-1:0]  len,
		input logic [NEXT_W-1:0] nxt
	);
		logic [NEXT_W-1:0] last_new;
		logic [NEXT_W-1:0] c;
		last_new = nxt - NEXT_W'(1);
		if (hdr <= cur) begin
			return cur;
		end
		c = (nxt == '0 || NEXT_W'(hdr) <= last_new) ? NEXT_W'(hdr) : last_new;
		if (c > NEXT_W'(len)) begin
			c = NEXT_W'(len);
		end
		return c[IDX_W-1:0];
	endfunction

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// Pick the table entry each message needs
	always_comb begin
		unique case (req.data.op)
			OP_VOTE:   rd_idx = NEXT_W'(log_len_q);
			OP_HEADER: rd_idx = NEXT_W'(req.data.index_arg);
			default:   rd_idx = next_idx_q;
		endcase
		rd_idx_m1 = rd_idx - NEXT_W'(1);
	end

	assign mem_req.rd_en   = accept;
	assign mem_req.rd_addr = rd_idx_m1[LOG_AW-1:0];
	assign mem_req.wr_en   = fire && wr_en;
	assign mem_req.wr_addr = wr_addr;
	assign mem_req.wr_data = item_s1.entry_term;

	rfr_term_mem u_term_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// Decide on the held message word
	always_comb begin
		logic              stale;
		logic              newer;
		logic              grant;
		logic [TERM_W-1:0] mine;
		logic [NEXT_W-1:0] idx;
		logic [NEXT_W-1:0] idx_m1;
		logic [IDX_W-1:0]  len1;

		stale  = item_s1.msg_term < cur_term_q;
		newer  = item_s1.msg_term > cur_term_q;
		grant  = 1'b0;
		mine   = '0;
		idx    = next_idx_q;
		idx_m1 = next_idx_q - NEXT_W'(1);
		len1   = log_len_q;

		term_d        = cur_term_q;
		voted_valid_d = voted_valid_q;
		voted_for_d   = voted_for_q;
		leader_d      = leader_q;
		log_len_d     = log_len_q;
		commit_d      = commit_q;
		pending_d     = pending_q;
		next_idx_d    = next_idx_q;
		hdr_commit_d  = hdr_commit_q;
		skip_d        = skip_q;
		ovf_d         = ovf_q;
		wr_en         = 1'b0;
		wr_addr       = idx_m1[LOG_AW-1:0];
		has_res       = 1'b0;
		res           = '0;

		unique case (item_s1.op)
			OP_VOTE: begin
				pending_d = '0;
				skip_d    = 1'b0;
				has_res   = 1'b1;
				if (!stale) begin
					if (newer) begin
						term_d        = item_s1.msg_term;
						voted_valid_d = 1'b0;
						voted_for_d   = '0;
						leader_d      = '0;
					end
					mine  = (log_len_q == '0) ? '0 : rd_data;
					grant = (!voted_valid_d || voted_for_d == item_s1.peer_id) &&
						(item_s1.term_arg > mine ||
						(item_s1.term_arg == mine && item_s1.index_arg >= log_len_q));
					if (grant) begin
						voted_valid_d = 1'b1;
						voted_for_d   = item_s1.peer_id;
					end
				end
				res.reply_kind = KIND_VOTE;
				res.ok         = grant;
			end
			OP_HEADER: begin
				pending_d      = item_s1.entry_count;
				skip_d         = 1'b1;
				ovf_d          = 1'b0;
				has_res        = 1'b1;
				res.reply_kind = KIND_APPEND;
				if (!stale) begin
					if (newer) begin
						term_d        = item_s1.msg_term;
						voted_valid_d = 1'b0;
						voted_for_d   = '0;
					end
					leader_d = item_s1.peer_id;
					if (item_s1.index_arg != '0 && item_s1.index_arg > log_len_q) begin
						res.conflict_index = log_len_q + IDX_W'(1);
					end else if (item_s1.index_arg != '0 && rd_data != item_s1.term_arg) begin
						res.conflict_index = item_s1.index_arg;
						res.conflict_term  = rd_data;
					end else begin
						// Open the entry run
						skip_d       = 1'b0;
						next_idx_d   = NEXT_W'(item_s1.index_arg) + NEXT_W'(1);
						hdr_commit_d = item_s1.leader_commit;
						if (item_s1.entry_count == '0) begin
							commit_d = commit_calc(item_s1.leader_commit, commit_q,
								log_len_q, next_idx_d);
							res.ok   = 1'b1;
						end else begin
							has_res = 1'b0;
						end
					end
				end
			end
			OP_ENTRY: begin
				if (pending_q != '0) begin
					pending_d = pending_q - IDX_W'(1);
					if (skip_q) begin
						if (pending_d == '0) begin
							skip_d = 1'b0;
						end
					end else begin
						// Truncate on a term conflict, then append or flag a full log
						if (idx != '0 && idx <= NEXT_W'(log_len_q) &&
							rd_data != item_s1.entry_term) begin
							len1 = idx_m1[IDX_W-1:0];
						end
						if (idx > NEXT_W'(len1)) begin
							if (idx != '0 && idx <= NEXT_W'(LOG_DEPTH) &&
								idx == NEXT_W'(len1) + NEXT_W'(1)) begin
								wr_en = 1'b1;
								len1  = idx[IDX_W-1:0];
							end else begin
								ovf_d = 1'b1;
							end
						end
						log_len_d  = len1;
						next_idx_d = idx + NEXT_W'(1);
						if (pending_d == '0) begin
							has_res        = 1'b1;
							res.reply_kind = KIND_APPEND;
							res.ok         = 1'b1;
							res.log_full   = ovf_d;
							commit_d = commit_calc(hdr_commit_q, commit_q, log_len_d,
								next_idx_d);
						end
					end
				end
			end
			default: begin
				has_res = 1'b0;
			end
		endcase

		res.reply_term = term_d;
		res.commit_now = commit_d;
		res.leader_now = leader_d;
	end

	assign fire = (state_q == ST_EXEC) && (!has_res || !rsp_valid_q || rsp.ready);

	// Hold the accepted word for the decision cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req.data;
		end
	end

	// Sequencer and reply register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fire && has_res) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_res) begin
			rsp_q <= res;
		end
	end

	// Advance node state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_term_q    <= '0;
			voted_valid_q <= 1'b0;
			voted_for_q   <= '0;
			leader_q      <= '0;
			log_len_q     <= '0;
			commit_q      <= '0;
			pending_q     <= '0;
			next_idx_q    <= '0;
			hdr_commit_q  <= '0;
			skip_q        <= 1'b0;
			ovf_q         <= 1'b0;
		end else if (fire) begin
			cur_term_q    <= term_d;
			voted_valid_q <= voted_valid_d;
			voted_for_q   <= voted_for_d;
			leader_q      <= leader_d;
			log_len_q     <= log_len_d;
			commit_q      <= commit_d;
			pending_q     <= pending_d;
			next_idx_q    <= next_idx_d;
			hdr_commit_q  <= hdr_commit_d;
			skip_q        <= skip_d;
			ovf_q         <= ovf_d;
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("accepted word did not enter the decision cycle");

	a_reply_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> (rsp_valid_q && $stable(rsp_q)))
		else $error("stalled reply word changed or dropped");

	a_log_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		log_len_q <= IDX_W'(LOG_DEPTH))
		else $error("log length beyond table depth");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && has_res && rsp_valid_q && !rsp.ready)
		|=> state_q == ST_EXEC)
		else $error("decision left while reply register blocked");

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Raft follower message handler. A shadow of the
// follower state predicts every reply word from the message words taken by the
// block. Directed words come first, then random votes, append runs and stray words,
// with long runs that fill the term table past its end. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
	import rfr_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int MAX_IDX      = LOG_DEPTH;
	localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(LOG_DEPTH);
	localparam int WORD_TARGET  = 1850;
	localparam int FILL_AT      = 400;
	localparam int STEADY_END   = 700;
	localparam int LATE_WORDS   = 1700;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 200000;

	// Shadow of the follower state; predicts and checks reply words
	class follower_mirror;
		logic [TERM_W-1:0] cur_term;
		bit                voted;
		logic [PEER_W-1:0] vote_peer;
		logic [PEER_W-1:0] leader;
		logic [TERM_W-1:0] log_terms [LOG_DEPTH];
		int unsigned       log_len;
		int unsigned       commit_idx;
		int unsigned       entries_left;
		int unsigned       next_idx;
		int unsigned       hdr_commit;
		bit                discard_run;
		bit                full_seen;
		rsp_t              replies_due [$];
		int                fails;

		function new();
			cur_term     = '0;
			voted        = 1'b0;
			vote_peer    = '0;
			leader       = '0;
			log_len      = 0;
			commit_idx   = 0;
			entries_left = 0;
			next_idx     = 0;
			hdr_commit   = 0;
			discard_run  = 1'b0;
			full_seen    = 1'b0;
			fails        = 0;
			foreach (log_terms[i]) log_terms[i] = '0;
		endfunction

		function logic [TERM_W-1:0] last_term();
			return (log_len == 0) ? '0 : log_terms[log_len - 1];
		endfunction

		function void adopt(logic [TERM_W-1:0] t);
			cur_term  = t;
			voted     = 1'b0;
			vote_peer = '0;
			leader    = '0;
		endfunction

		function void push_reply(logic kind, logic ok, int unsigned cidx,
				logic [TERM_W-1:0] cterm, logic full);
			rsp_t r;
			r.reply_kind     = kind;
			r.reply_term     = cur_term;
			r.ok             = ok;
			r.conflict_index = cidx[IDX_W-1:0];
			r.conflict_term  = cterm;
			r.commit_now     = commit_idx[IDX_W-1:0];
			r.leader_now     = leader;
			r.log_full       = full;
			replies_due.insert(replies_due.size(), r);
		endfunction

		// Advance the commit index and reply success at the end of an append
		function void close_append();
			int unsigned top;
			int unsigned c;
			if (hdr_commit > commit_idx) begin
				top = next_idx - 1;
				c = (hdr_commit < top) ? hdr_commit : top;
				if (c > log_len)
					c = log_len;
				commit_idx = c & 'h7FF;
			end
			push_reply(KIND_APPEND, 1'b1, 0, '0, full_seen);
		endfunction

		// Note one accepted message word; returns 0 when the block ignores it
		function bit take_message(req_t w);
			bit                grant;
			logic [TERM_W-1:0] mine;
			int unsigned       idx;
			case (w.op)
				OP_VOTE: begin
					entries_left = 0;
					discard_run  = 1'b0;
					if (w.msg_term < cur_term) begin
						push_reply(KIND_VOTE, 1'b0, 0, '0, 1'b0);
						return 1'b1;
					end
					if (w.msg_term > cur_term)
						adopt(w.msg_term);
					mine = last_term();
					grant = (!voted || vote_peer == w.peer_id) &&
						(w.term_arg > mine || (w.term_arg == mine &&
						32'(w.index_arg) >= log_len));
					if (grant) begin
						voted     = 1'b1;
						vote_peer = w.peer_id;
					end
					push_reply(KIND_VOTE, grant, 0, '0, 1'b0);
					return 1'b1;
				end
				OP_HEADER: begin
					entries_left = 32'(w.entry_count);
					discard_run  = 1'b1;
					full_seen    = 1'b0;
					if (w.msg_term < cur_term) begin
						push_reply(KIND_APPEND, 1'b0, 0, '0, 1'b0);
						return 1'b1;
					end
					if (w.msg_term > cur_term)
						adopt(w.msg_term);
					leader = w.peer_id;
					if (w.index_arg > 0) begin
						if (32'(w.index_arg) > log_len) begin
							push_reply(KIND_APPEND, 1'b0, log_len + 1, '0, 1'b0);
							return 1'b1;
						end
						if (log_terms[w.index_arg - 1] != w.term_arg) begin
							push_reply(KIND_APPEND, 1'b0, 32'(w.index_arg),
								log_terms[w.index_arg - 1], 1'b0);
							return 1'b1;
						end
					end
					discard_run = 1'b0;
					next_idx    = 32'(w.index_arg) + 1;
					hdr_commit  = 32'(w.leader_commit);
					if (entries_left == 0)
						close_append();
					return 1'b1;
				end
				OP_ENTRY: begin
					if (entries_left == 0)
						return 1'b0;
					entries_left--;
					// Drain entries of a rejected header without touching the log
					if (discard_run) begin
						if (entries_left == 0)
							discard_run = 1'b0;
						return 1'b1;
					end
					idx = next_idx;
					// Truncate on a term conflict, then append or refuse past the end
					if (idx >= 1 && idx <= log_len && log_terms[idx - 1] != w.entry_term)
						log_len = idx - 1;
					if (idx > log_len) begin
						if (idx >= 1 && idx - 1 < LOG_DEPTH && idx == log_len + 1) begin
							log_terms[idx - 1] = w.entry_term;
							log_len = idx;
						end else begin
							full_seen = 1'b1;
						end
					end
					next_idx = (idx + 1) & 'hFFF;
					if (entries_left == 0)
						close_append();
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		endfunction

		function void check_field(string name, logic [TERM_W-1:0] want,
				logic [TERM_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				fails++;
			end
		endfunction

		// Compare one reply word with the oldest prediction
		function void match_reply(rsp_t got);
			rsp_t want;
			if (replies_due.size() == 0) begin
				$error("reply word with none expected");
				fails++;
				return;
			end
			want = replies_due.pop_front();
			check_field("reply_kind", 32'(want.reply_kind), 32'(got.reply_kind));
			check_field("reply_term", want.reply_term, got.reply_term);
			check_field("ok", 32'(want.ok), 32'(got.ok));
			check_field("conflict_index", 32'(want.conflict_index),
				32'(got.conflict_index));
			check_field("conflict_term", want.conflict_term, got.conflict_term);
			check_field("commit_now", 32'(want.commit_now), 32'(got.commit_now));
			check_field("leader_now", 32'(want.leader_now), 32'(got.leader_now));
			check_field("log_full", 32'(want.log_full), 32'(got.log_full));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   steady = 1'b0;
	int   busy_words = 0;
	int   cycle_count = 0;
	follower_mirror mirror;

	rfr_req_if req_if ();
	rfr_rsp_if rsp_if ();

	raft_follower_rpc_handler_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #5 clk = ~clk;

	// Stall the reply channel at random outside the steady stretch
	always @(posedge clk) begin
		rsp_if.ready <= steady || ($urandom_range(0, 99) >= 28);
	end

	// Check every reply word taken
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			mirror.match_reply(rsp_if.data);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Present one message word, idling at random first; hold until taken
	task automatic send_word(req_t w);
		while (!steady && $urandom_range(0, 99) < 28) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= w;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		if (mirror.take_message(w))
			busy_words++;
		steady = (busy_words >= FILL_AT && busy_words < STEADY_END);
	endtask

	function automatic req_t mk(logic [OP_W-1:0] op, logic [TERM_W-1:0] mt,
			logic [PEER_W-1:0] peer, logic [IDX_W-1:0] ia, logic [TERM_W-1:0] ta,
			logic [IDX_W-1:0] lc, logic [IDX_W-1:0] cnt, logic [TERM_W-1:0] et);
		req_t w;
		w.op            = op;
		w.msg_term      = mt;
		w.peer_id       = peer;
		w.index_arg     = ia;
		w.term_arg      = ta;
		w.leader_commit = lc;
		w.entry_count   = cnt;
		w.entry_term    = et;
		return w;
	endfunction

	// Random fields everywhere; callers overwrite the ones that matter
	function automatic req_t noise_word(logic [OP_W-1:0] op);
		return mk(op, $urandom, PEER_W'($urandom_range(0, 15)),
			IDX_W'($urandom_range(0, MAX_IDX)), $urandom,
			IDX_W'($urandom_range(0, MAX_IDX)), IDX_W'($urandom_range(0, MAX_IDX)),
			$urandom);
	endfunction

	// Mostly the current term, some stale, some newer, late jumps to the top
	function automatic logic [TERM_W-1:0] pick_msg_term();
		int unsigned       roll;
		logic [TERM_W-1:0] cur;
		cur  = mirror.cur_term;
		roll = $urandom_range(0, 99);
		if (busy_words > LATE_WORDS && roll < 4)
			return 32'hFFFF_FFF0 | $urandom_range(0, 15);
		if (roll < 8 && cur != 0)
			return cur - $urandom_range(1, 3);
		if (roll < 80)
			return cur;
		return cur + $urandom_range(1, 3);
	endfunction

	task automatic send_vote();
		req_t              w;
		int unsigned       roll;
		int                ia;
		logic [TERM_W-1:0] mine;
		w = noise_word(OP_VOTE);
		w.msg_term = pick_msg_term();
		if ($urandom_range(0, 1))
			w.peer_id = mirror.vote_peer;
		mine = mirror.last_term();
		ia   = int'(mirror.log_len) + $urandom_range(0, 4) - 2;
		ia   = (ia < 0) ? 0 : (ia > MAX_IDX) ? MAX_IDX : ia;
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			w.term_arg  = mine;
			w.index_arg = IDX_W'(ia);
		end else if (roll < 60) begin
			w.term_arg = mine + 1;
		end else if (roll < 80) begin
			w.term_arg  = mine - 1;
			w.index_arg = IDX_W'(ia);
		end
		send_word(w);
	endtask

	// One append run: header plus its entries, sometimes broken or cut short
	task automatic send_append();
		req_t        w;
		int unsigned roll;
		int unsigned len;
		int unsigned prev;
		int unsigned count;
		int unsigned sent;
		int unsigned pos;
		int unsigned cap;
		w    = noise_word(OP_HEADER);
		len  = mirror.log_len;
		roll = $urandom_range(0, 99);
		w.msg_term = pick_msg_term();
		if (roll < 55)
			prev = len;
		else if (roll < 92 || len >= MAX_IDX)
			prev = $urandom_range(0, len);
		else
			prev = $urandom_range(len + 1, MAX_IDX);
		if (prev > 0 && prev <= len)
			w.term_arg = mirror.log_terms[prev - 1];
		if (roll >= 85 && roll < 92 && prev > 0 && prev <= len)
			w.term_arg = w.term_arg ^ (32'd1 << $urandom_range(0, 31));
		roll = $urandom_range(0, 99);
		count = (roll < 10) ? 0 : (roll < 90) ? $urandom_range(1, 6) : $urandom_range(7, 20);
		cap = prev + count + 1;
		if (cap > MAX_IDX)
			cap = MAX_IDX;
		w.leader_commit = ($urandom_range(0, 99) < 70) ? IDX_W'($urandom_range(0, cap)) :
			IDX_W'($urandom_range(0, MAX_IDX));
		w.index_arg   = IDX_W'(prev);
		w.entry_count = IDX_W'(count);
		send_word(w);
		// Cut some runs short so the next message abandons them
		sent = count;
		if (count > 0 && $urandom_range(0, 99) < 8)
			sent = $urandom_range(0, count - 1);
		for (int k = 0; k < sent; k++) begin
			w   = noise_word(OP_ENTRY);
			pos = prev + 1 + k;
			if (pos <= mirror.log_len && $urandom_range(0, 99) < 70)
				w.entry_term = mirror.log_terms[pos - 1];
			else if ($urandom_range(0, 1))
				w.entry_term = mirror.cur_term;
			send_word(w);
		end
	endtask

	// Grow the log past the table end with long clean runs
	task automatic fill_table();
		req_t        w;
		int unsigned len;
		int unsigned count;
		bit          overflowed;
		overflowed = 1'b0;
		while (!overflowed) begin
			len   = mirror.log_len;
			count = (MAX_IDX + 4 - len > MAX_IDX) ? MAX_IDX : MAX_IDX + 4 - len;
			overflowed = (len + count > MAX_IDX);
			w = noise_word(OP_HEADER);
			w.msg_term      = mirror.cur_term;
			w.index_arg     = IDX_W'(len);
			w.term_arg      = (len > 0) ? mirror.log_terms[len - 1] : $urandom;
			w.leader_commit = TOP_IDX;
			w.entry_count   = IDX_W'(count);
			send_word(w);
			for (int k = 0; k < count; k++) begin
				w = noise_word(OP_ENTRY);
				w.entry_term = mirror.cur_term;
				send_word(w);
			end
		end
	endtask

	task automatic run_directed();
		// Votes on an empty log: grant, then refuse a second candidate
		send_word(mk(OP_VOTE, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(OP_VOTE, 0, 5, TOP_IDX, '1, 0, 0, 0));
		// Newer term header with two entries, commit capped by the log
		send_word(mk(OP_HEADER, 1, 15, 0, 0, TOP_IDX, 2, 0));
		send_word(mk(OP_ENTRY, 0, 0, 0, 0, 0, 0, 1));
		send_word(mk(OP_ENTRY, 0, 0, 0, 0, 0, 0, '1));
		// Previous index past the log; its entry is drained
		send_word(mk(OP_HEADER, 1, 3, TOP_IDX, 0, 0, 1, 0));
		send_word(mk(OP_ENTRY, 0, 0, 0, 0, 0, 0, 5));
		// Previous term mismatch
		send_word(mk(OP_HEADER, 1, 3, 2, 5, 0, 0, 0));
		// Stale header and its drained entry, then a stray entry and an unused op
		send_word(mk(OP_HEADER, 0, 2, 0, 0, 0, 1, 0));
		send_word(mk(OP_ENTRY, 0, 0, 0, 0, 0, 0, 3));
		send_word(mk(OP_ENTRY, '1, 15, TOP_IDX, '1, TOP_IDX, TOP_IDX, '1));
		send_word(mk(OP_UNUSED, '1, 15, TOP_IDX, '1, TOP_IDX, TOP_IDX, '1));
		// Conflicting entry truncates; a vote interrupts the run
		send_word(mk(OP_HEADER, 1, 7, 1, 1, 2, 3, 0));
		send_word(mk(OP_ENTRY, 0, 0, 0, 0, 0, 0, 7));
		send_word(mk(OP_ENTRY, 0, 0, 0, 0, 0, 0, 9));
		send_word(mk(OP_VOTE, 2, 9, TOP_IDX, '1, 0, 0, 0));
		send_word(mk(OP_ENTRY, 0, 0, 0, 0, 0, 0, 4));
		// Same candidate again, another candidate, a stale vote
		send_word(mk(OP_VOTE, 2, 9, 3, 9, 0, 0, 0));
		send_word(mk(OP_VOTE, 2, 4, 3, 9, 0, 0, 0));
		send_word(mk(OP_VOTE, 1, 4, 3, 9, 0, 0, 0));
		// Heartbeat commits, then one entry with a large leader commit
		send_word(mk(OP_HEADER, 2, 1, 3, 9, 3, 0, 0));
		send_word(mk(OP_HEADER, 2, 1, 3, 9, TOP_IDX, 1, 0));
		send_word(mk(OP_ENTRY, 0, 0, 0, 0, 0, 0, 9));
	endtask

	task automatic run_random();
		int unsigned roll;
		bit          filled;
		filled = 1'b0;
		while (busy_words < WORD_TARGET) begin
			if (!filled && busy_words >= FILL_AT) begin
				fill_table();
				filled = 1'b1;
			end
			roll = $urandom_range(0, 99);
			if (roll < 22)
				send_vote();
			else if (roll < 92)
				send_append();
			else
				send_word(noise_word($urandom_range(0, 1) ? OP_ENTRY : OP_UNUSED));
		end
	endtask

	initial begin
		mirror = new();
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		req_if.valid <= 1'b0;
		// Wait for outstanding replies, then let the pipeline settle
		while (mirror.replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.fails == 0 && mirror.replies_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
